// ===== rtl/bwc_pkg.sv =====
package bwc_pkg;

  typedef struct packed {
    logic        new_valid;
    logic        operation;
    logic [31:0] cpu_addr;
    logic [31:0] cpu_wdata;
    logic [7:0]  cpu_tag;
    logic        mem_ready;
    logic        mem_resp_valid;
    logic [63:0] mem_resp_data;
  } bwc_in_t;

  typedef struct packed {
    logic        resp_valid;
    logic [31:0] resp_data;
    logic [7:0]  resp_tag;
    logic        busy_res;
    logic        mem_req_valid;
    logic        mem_req_store;
    logic [31:0] mem_req_addr;
    logic [63:0] mem_req_data;
  } bwc_out_t;

  typedef enum logic [1:0] {
    ST_READY     = 2'd0,
    ST_RESOLVE   = 2'd1,
    ST_WRITEBACK = 2'd2,
    ST_REFILL    = 2'd3
  } bwc_state_e;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

endpackage

// ===== rtl/blocking_writeback_cache_top.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | bwc_in_t: one controller tick
// out     | output    | out_valid_o / out_stall_i | bwc_out_t: result of the tick
// Each request runs through the phases accept, read the tag row of the set, read one
// line beat, then evaluate, write back and load the output register.
// Stall the input while a request is in progress and while a result waits on a
// stalled output; the next request enters on the edge the result leaves.
// Reset clears valid, dirty and victim bits in flops and the controller state.
// Tag and line data memories have no reset.
module blocking_writeback_cache_top #(
  parameter int WORD_SEL_BITS  = 2,
  parameter int INDEX_BITS     = 6,
  parameter int WAYS           = 2,
  parameter int WORDS_PER_BEAT = 2,
  parameter int BEATS_PER_LINE = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bwc_pkg::bwc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bwc_pkg::bwc_out_t out_data_o
);
  import bwc_pkg::*;

  localparam int LINE_SHIFT = 2 + WORD_SEL_BITS;
  localparam int TAG_SHIFT  = LINE_SHIFT + INDEX_BITS;
  localparam int TAG_W      = 32 - TAG_SHIFT;
  localparam int NUM_SETS   = 1 << INDEX_BITS;
  localparam int LINE_WORDS = WORDS_PER_BEAT * BEATS_PER_LINE;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BEAT_W     = (BEATS_PER_LINE > 1) ? $clog2(BEATS_PER_LINE) : 1;
  localparam int CNT_W      = $clog2(BEATS_PER_LINE + 1);
  localparam int LW_W       = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int NUM_LINES  = NUM_SETS * WAYS;
  localparam int NUM_BEATS  = NUM_LINES * BEATS_PER_LINE;
  localparam int LN_W       = $clog2(NUM_LINES) > 0 ? $clog2(NUM_LINES) : 1;
  localparam int BI_W       = $clog2(NUM_BEATS) > 0 ? $clog2(NUM_BEATS) : 1;
  localparam logic [63:0] BEAT_MASK =
    (WORDS_PER_BEAT >= 2) ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_READ = 2'd1,
    PH_EVAL = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  phase_e phase_q, phase_d;

  logic [TAG_W-1:0] tag_mem  [NUM_SETS][WAYS];
  logic [63:0]      beat_mem [NUM_BEATS];
  logic [TAG_W-1:0] tag_rd_q [WAYS];
  logic [63:0]      beat_rd_q;

  logic [NUM_LINES-1:0] valid_q, dirty_q;
  logic [NUM_SETS-1:0][WAY_W-1:0] victim_q;

  bwc_state_e       st_q;
  logic             pv_q, pstore_q;
  logic [31:0]      paddr_q, pwdata_q;
  logic [7:0]       ptag_q;
  logic [CNT_W-1:0] wb_q, rc_q, rb_q;
  logic             shown_q;

  bwc_in_t  it_q;
  bwc_out_t res_q;
  logic     out_v_q;

  bwc_out_t             res_d;
  logic                 pv_d;
  bwc_state_e           st_d;
  logic [CNT_W-1:0]     wb_d, rc_d, rb_d;
  logic                 shown_d;
  logic [NUM_LINES-1:0] valid_d, dirty_d;
  logic [NUM_SETS-1:0][WAY_W-1:0] victim_d;
  logic                 out_v_d;

  // tick-local view after request latch and memory handshake
  logic             v_pv, v_store;
  logic [31:0]      v_addr, v_wdata;
  logic [7:0]       v_ptag;
  bwc_state_e       v_st;
  logic [CNT_W-1:0] v_wb, v_rc;
  logic [INDEX_BITS-1:0] v_set;
  logic [LW_W-1:0]  v_word;
  logic [TAG_W-1:0] v_tag;
  logic [WAY_W-1:0] v_vway;
  logic [LN_W-1:0]  v_vline;
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic [BEAT_W-1:0] rd_beat;
  logic [WAY_W-1:0] rd_way;
  logic [BI_W-1:0]  rd_addr;

  // wrap the word select into the words a line holds
  function automatic logic [LW_W-1:0] wrap_word(logic [WORD_SEL_BITS-1:0] sel);
    logic [LW_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << WORD_SEL_BITS); i++) begin
      if (sel == WORD_SEL_BITS'(i)) r = LW_W'(i % LINE_WORDS);
    end
    return r;
  endfunction

  assign in_stall_o  = (phase_q != PH_IDLE) || (out_v_q && out_stall_i);
  assign out_valid_o = out_v_q;
  assign out_data_o  = res_q;
  assign out_v_d     = (phase_q == PH_DONE) || (out_v_q && out_stall_i);

  always_comb begin
    v_pv = pv_q; v_store = pstore_q; v_addr = paddr_q;
    v_wdata = pwdata_q; v_ptag = ptag_q;
    if (it_q.new_valid && !pv_q) begin
      v_pv = 1'b1; v_store = it_q.operation; v_addr = it_q.cpu_addr;
      v_wdata = it_q.cpu_wdata; v_ptag = it_q.cpu_tag;
    end
    v_st = st_q; v_wb = wb_q; v_rc = rc_q;
    if (shown_q && it_q.mem_ready) begin
      if (st_q == ST_WRITEBACK) begin
        if (wb_q == CNT_W'(BEATS_PER_LINE - 1)) v_st = ST_REFILL;
        v_wb = wb_q + 1'b1;
      end else if (st_q == ST_REFILL) begin
        v_rc = rc_q + 1'b1;
      end
    end
    v_set  = v_addr[LINE_SHIFT +: INDEX_BITS];
    v_word = wrap_word(v_addr[2 +: WORD_SEL_BITS]);
    v_tag  = v_addr[31 -: TAG_W];
    v_vway = victim_q[v_set];
    v_vline = LN_W'(32'(v_set) * WAYS + 32'(v_vway));
    hit = 1'b0; hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_q[LN_W'(32'(v_set) * WAYS + w)] && tag_rd_q[w] == v_tag) begin
        hit = 1'b1; hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    rd_way  = hit_way;
    rd_beat = BEAT_W'(32'(v_word) / WORDS_PER_BEAT);
    if (v_st == ST_WRITEBACK) begin
      rd_way  = v_vway;
      rd_beat = BEAT_W'(v_wb);
    end
    rd_addr = BI_W'((32'(v_set) * WAYS + 32'(rd_way)) * BEATS_PER_LINE + 32'(rd_beat));
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: if (in_valid_i && !in_stall_o) phase_d = PH_READ;
      PH_READ: phase_d = PH_EVAL;
      PH_EVAL: phase_d = PH_DONE;
      PH_DONE: phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && in_valid_i && !in_stall_o) it_q <= in_data_i;
    if (phase_q == PH_READ) begin
      for (int w = 0; w < WAYS; w++) tag_rd_q[w] <= tag_mem[v_set][w];
    end
    if (phase_q == PH_EVAL) beat_rd_q <= beat_mem[rd_addr];
  end

  logic [BI_W-1:0] refill_addr;
  logic [5:0]      sh;
  assign refill_addr = BI_W'(32'(v_vline) * BEATS_PER_LINE + 32'(rb_q));
  assign sh = 6'(32'(32'(v_word) % WORDS_PER_BEAT) * 32);

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_DONE) begin
      if ((v_st == ST_READY || v_st == ST_RESOLVE) && v_pv && hit && v_store)
        beat_mem[rd_addr] <= (beat_rd_q & ~(64'hFFFF_FFFF << sh)) |
                             (64'(v_wdata) << sh);
      if (v_st == ST_REFILL && it_q.mem_resp_valid &&
          rb_q < CNT_W'(BEATS_PER_LINE)) begin
        beat_mem[refill_addr] <= it_q.mem_resp_data & BEAT_MASK;
        if (rb_q == CNT_W'(BEATS_PER_LINE - 1)) tag_mem[v_set][v_vway] <= v_tag;
      end
    end
  end

  always_comb begin
    res_d    = '0;
    pv_d     = v_pv;
    st_d     = v_st;
    wb_d     = v_wb;
    rc_d     = v_rc;
    rb_d     = rb_q;
    shown_d  = 1'b0;
    valid_d  = valid_q;
    dirty_d  = dirty_q;
    victim_d = victim_q;
    if (v_st == ST_READY || v_st == ST_RESOLVE) begin
      if (v_pv && hit) begin
        if (v_store) begin
          dirty_d[LN_W'(32'(v_set) * WAYS + 32'(hit_way))] = 1'b1;
        end else begin
          res_d.resp_valid = 1'b1;
          res_d.resp_data  = 32'(beat_rd_q >> sh);
          res_d.resp_tag   = v_ptag;
        end
      end
      pv_d = v_pv && !hit;
      if (!v_pv || hit) st_d = ST_READY;
      else st_d = dirty_q[v_vline] ? ST_WRITEBACK : ST_REFILL;
      wb_d = '0; rc_d = '0; rb_d = '0;
    end else if (v_st == ST_WRITEBACK) begin
      if (v_wb < CNT_W'(BEATS_PER_LINE)) begin
        shown_d = 1'b1;
        res_d.mem_req_valid = 1'b1;
        res_d.mem_req_store = 1'b1;
        res_d.mem_req_addr  = {tag_rd_q[v_vway], v_set, LINE_SHIFT'(0)} +
                              32'(32'(v_wb) * WORDS_PER_BEAT * 4);
        res_d.mem_req_data  = beat_rd_q & BEAT_MASK;
      end
    end else begin
      if (v_rc == '0) begin
        shown_d = 1'b1;
        res_d.mem_req_valid = 1'b1;
        res_d.mem_req_addr  = {v_addr[31:LINE_SHIFT], LINE_SHIFT'(0)};
      end
      if (it_q.mem_resp_valid && rb_q < CNT_W'(BEATS_PER_LINE)) begin
        rb_d = rb_q + 1'b1;
        if (rb_q == CNT_W'(BEATS_PER_LINE - 1)) begin
          dirty_d[v_vline] = 1'b0;
          valid_d[v_vline] = 1'b1;
          victim_d[v_set]  = (32'(v_vway) + 1 >= WAYS) ? '0 : v_vway + 1'b1;
          st_d = ST_RESOLVE;
        end
      end
    end
    res_d.busy_res = pv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; out_v_q <= 1'b0; st_q <= ST_READY; pv_q <= 1'b0;
      pstore_q <= 1'b0; paddr_q <= '0; pwdata_q <= '0; ptag_q <= '0;
      wb_q <= '0; rc_q <= '0; rb_q <= '0; shown_q <= 1'b0; res_q <= '0;
      valid_q <= '0; dirty_q <= '0; victim_q <= '0;
    end else begin
      phase_q <= phase_d;
      out_v_q <= out_v_d;
      if (phase_q == PH_DONE) begin
        res_q <= res_d;
        pv_q <= pv_d;
        pstore_q <= v_store; paddr_q <= v_addr; pwdata_q <= v_wdata; ptag_q <= v_ptag;
        st_q <= st_d; wb_q <= wb_d; rc_q <= rc_d; rb_q <= rb_d;
        shown_q <= shown_d;
        valid_q <= valid_d; dirty_q <= dirty_d; victim_q <= victim_d;
      end
    end
  end

endmodule

// ===== rtl/bwc_checker.sv =====
module bwc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input bwc_pkg::bwc_out_t out_data_o
);
  import bwc_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.resp_valid |-> out_data_o.resp_data == '0)
    else $error("response data without valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.mem_req_valid |-> out_data_o.mem_req_addr == '0)
    else $error("memory address without request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.resp_valid |-> !out_data_o.mem_req_valid)
    else $error("hit response with memory request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while one in progress");

endmodule

bind blocking_writeback_cache_top bwc_checker u_bwc_checker (.*);

// ===== tb/sv/blocking_writeback_cache_top_test.sv =====
`timescale 1ns / 1ps

module blocking_writeback_cache_top_test;
  import bwc_pkg::*;

  localparam int TICK_TARGET = 850;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic        op;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [7:0]  tag;
    bit          has_exp;
    bwc_out_t    exp_first;
  } cpu_row_t;

  typedef struct {
    bit          valid;
    logic        op;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [7:0]  tag;
  } pend_req_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  bwc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bwc_out_t out_data;

  bwc_in_t  tick_q[$];
  bwc_out_t tick_result_q[$];
  int       sent = 0;
  int       got = 0;
  int       errors = 0;
  int       cyc = 0;
  int       hold = 0;
  bit       held = 1'b0;
  bit       gen_done = 1'b0;

  logic [21:0] ltag   [128];
  bit          lvalid [128];
  bit          ldirty [128];
  logic [63:0] lbeats [256];
  bit          victim [64];
  bwc_state_e  ctrl;
  pend_req_t   pend;
  int          wb_beat, rd_count, rf_beat;
  bit          shown;
  bit          last_shown;

  blocking_writeback_cache_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic bwc_out_t cache_tick(bwc_in_t t);
    bwc_out_t    o;
    logic [5:0]  set;
    logic [1:0]  word;
    logic [21:0] tg;
    int          vline, ln, bi, sh;
    bit          hit;
    o = '0;
    if (t.new_valid && !pend.valid) begin
      pend = '{1'b1, t.operation, t.cpu_addr, t.cpu_wdata, t.cpu_tag};
    end
    if (shown && t.mem_ready) begin
      if (ctrl == ST_WRITEBACK) begin
        if (wb_beat == 1) ctrl = ST_REFILL;
        wb_beat++;
      end else if (ctrl == ST_REFILL) begin
        rd_count++;
      end
    end
    shown = 1'b0;
    set   = pend.addr[9:4];
    word  = pend.addr[3:2];
    tg    = pend.addr[31:10];
    vline = set * 2 + victim[set];
    if (ctrl == ST_READY || ctrl == ST_RESOLVE) begin
      hit = 1'b0;
      for (int w = 0; w < 2; w++) begin
        ln = set * 2 + w;
        if (lvalid[ln] && ltag[ln] == tg) begin
          hit = 1'b1;
          if (pend.valid) begin
            bi = ln * 2 + word[1];
            sh = word[0] * 32;
            if (pend.op == OP_STORE) begin
              ldirty[ln] = 1'b1;
              lbeats[bi][sh +: 32] = pend.wdata;
            end else begin
              o.resp_valid = 1'b1;
              o.resp_data  = lbeats[bi][sh +: 32];
              o.resp_tag   = pend.tag;
            end
            pend.valid = 1'b0;
          end
        end
      end
      if (!pend.valid || hit) ctrl = ST_READY;
      else ctrl = ldirty[vline] ? ST_WRITEBACK : ST_REFILL;
      wb_beat  = 0;
      rd_count = 0;
      rf_beat  = 0;
    end else if (ctrl == ST_WRITEBACK) begin
      if (wb_beat < 2) begin
        shown           = 1'b1;
        o.mem_req_valid = 1'b1;
        o.mem_req_store = 1'b1;
        o.mem_req_addr  = {ltag[vline], set, 4'b0} + wb_beat * 8;
        o.mem_req_data  = lbeats[vline * 2 + wb_beat];
      end
    end else begin
      if (rd_count == 0) begin
        shown           = 1'b1;
        o.mem_req_valid = 1'b1;
        o.mem_req_addr  = {pend.addr[31:4], 4'b0};
      end
      if (t.mem_resp_valid && rf_beat < 2) begin
        lbeats[vline * 2 + rf_beat] = t.mem_resp_data;
        if (rf_beat == 1) begin
          ltag[vline]   = tg;
          ldirty[vline] = 1'b0;
          lvalid[vline] = 1'b1;
          victim[set]   = ~victim[set];
          ctrl          = ST_RESOLVE;
        end
        rf_beat++;
      end
    end
    o.busy_res = pend.valid;
    return o;
  endfunction

  task automatic add_tick(bit nv, logic op, logic [31:0] addr, logic [31:0] wdata,
                          logic [7:0] tag, bit has_exp, bwc_out_t exp_val);
    bwc_in_t  t;
    bwc_out_t o;
    t.new_valid      = nv;
    t.operation      = op;
    t.cpu_addr       = addr;
    t.cpu_wdata      = wdata;
    t.cpu_tag        = tag;
    t.mem_ready      = last_shown ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) == 0);
    t.mem_resp_valid = (ctrl == ST_REFILL) ? ($urandom_range(0, 9) < 6)
                                           : ($urandom_range(0, 19) == 0);
    case ($urandom_range(0, 7))
      0:       t.mem_resp_data = '0;
      1:       t.mem_resp_data = '1;
      default: t.mem_resp_data = {$urandom, $urandom};
    endcase
    o = cache_tick(t);
    last_shown = o.mem_req_valid;
    tick_q.push_back(t);
    tick_result_q.push_back(has_exp ? exp_val : o);
  endtask

  task automatic serve_request(cpu_row_t r);
    add_tick(1'b1, r.op, r.addr, r.wdata, r.tag, r.has_exp, r.exp_first);
    while (pend.valid) begin
      add_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), $urandom, $urandom,
               8'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  function automatic logic [31:0] pick_addr();
    logic [21:0] tg;
    logic [5:0]  set;
    if ($urandom_range(0, 9) == 0) return $urandom;
    case ($urandom_range(0, 5))
      0:       tg = 22'h3FFFFF;
      1:       tg = 22'($urandom);
      default: tg = 22'($urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 4))
      0:       set = 6'd63;
      1:       set = 6'($urandom);
      default: set = 6'($urandom_range(0, 1));
    endcase
    return {tg, set, 2'($urandom), 2'($urandom)};
  endfunction

  cpu_row_t rows[] = '{
    '{OP_LOAD,  32'hFFFF_FFFC, 32'h0,         8'hFF, 1'b1,
      '{1'b0, 32'h0, 8'h0, 1'b1, 1'b0, 1'b0, 32'h0, 64'h0}},
    '{OP_LOAD,  32'hFFFF_FFFC, 32'h0,         8'h00, 1'b0, '0},
    '{OP_STORE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'h01, 1'b0, '0},
    '{OP_LOAD,  32'hFFFF_FFF0, 32'h0,         8'h80, 1'b0, '0},
    '{OP_LOAD,  32'h0000_0000, 32'h0,         8'h00, 1'b0, '0},
    '{OP_STORE, 32'h0000_000C, 32'h0000_0000, 8'h02, 1'b0, '0},
    '{OP_STORE, 32'h0000_0004, 32'h5555_5555, 8'h03, 1'b0, '0},
    '{OP_LOAD,  32'h0000_0400, 32'h0,         8'h04, 1'b0, '0},
    '{OP_LOAD,  32'h0000_0800, 32'h0,         8'h05, 1'b0, '0},
    '{OP_LOAD,  32'h0000_000C, 32'h0,         8'h06, 1'b0, '0},
    '{OP_STORE, 32'h0000_0808, 32'hAAAA_AAAA, 8'h07, 1'b0, '0},
    '{OP_LOAD,  32'h0000_0C00, 32'h0,         8'h08, 1'b0, '0},
    '{OP_LOAD,  32'h0000_0808, 32'h0,         8'h09, 1'b0, '0},
    '{OP_STORE, 32'hFFFF_FFFC, 32'h1234_5678, 8'h0A, 1'b0, '0},
    '{OP_LOAD,  32'hFFFF_FBFC, 32'h0,         8'h0B, 1'b0, '0},
    '{OP_LOAD,  32'hFFFF_F7FC, 32'h0,         8'h0C, 1'b0, '0},
    '{OP_LOAD,  32'hFFFF_FFFC, 32'h0,         8'h0D, 1'b0, '0}
  };

  initial begin
    cpu_row_t r;
    for (int i = 0; i < 128; i++) begin
      lvalid[i] = 1'b0;
      ldirty[i] = 1'b0;
    end
    for (int i = 0; i < 64; i++) victim[i] = 1'b0;
    ctrl       = ST_READY;
    pend       = '{1'b0, 1'b0, 32'h0, 32'h0, 8'h0};
    wb_beat    = 0;
    rd_count   = 0;
    rf_beat    = 0;
    shown      = 1'b0;
    last_shown = 1'b0;
    foreach (rows[i]) serve_request(rows[i]);
    while (tick_q.size() < TICK_TARGET + 30) begin
      repeat ($urandom_range(0, 2)) begin
        add_tick(1'b0, 1'($urandom_range(0, 1)), $urandom, $urandom,
                 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      r.op      = 1'($urandom_range(0, 1));
      r.addr    = pick_addr();
      r.wdata   = $urandom;
      r.tag     = 8'($urandom_range(0, 255));
      r.has_exp = 1'b0;
      r.exp_first = '0;
      serve_request(r);
    end
    gen_done = 1'b1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (sent == tick_q.size() && tick_result_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  function automatic bit calm();
    return cyc >= 3000 && cyc < 5000;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
    end else if (gen_done && sent < tick_q.size() &&
                 (calm() || $urandom_range(0, 99) >= 32)) begin
      in_valid <= 1'b1;
      in_data  <= tick_q[sent];
      sent     <= sent + 1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold > 0) begin
      hold      <= hold - 1;
      out_stall <= 1'b1;
    end else if (!held && got >= 150) begin
      held      <= 1'b1;
      hold      <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm() && $urandom_range(0, 99) < 32;
    end
  end

  task automatic report(string field, logic [63:0] exp_val, logic [63:0] act_val);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_val, act_val);
    errors++;
  endtask

  always @(posedge clk_i) begin
    bwc_out_t e;
    if (rst_ni && out_valid && !out_stall) begin
      got <= got + 1;
      if (tick_result_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        errors++;
      end else begin
        e = tick_result_q.pop_front();
        if (out_data.resp_valid !== e.resp_valid)
          report("resp_valid", e.resp_valid, out_data.resp_valid);
        if (out_data.resp_data !== e.resp_data)
          report("resp_data", e.resp_data, out_data.resp_data);
        if (out_data.resp_tag !== e.resp_tag)
          report("resp_tag", e.resp_tag, out_data.resp_tag);
        if (out_data.busy_res !== e.busy_res)
          report("busy_res", e.busy_res, out_data.busy_res);
        if (out_data.mem_req_valid !== e.mem_req_valid)
          report("mem_req_valid", e.mem_req_valid, out_data.mem_req_valid);
        if (out_data.mem_req_store !== e.mem_req_store)
          report("mem_req_store", e.mem_req_store, out_data.mem_req_store);
        if (out_data.mem_req_addr !== e.mem_req_addr)
          report("mem_req_addr", e.mem_req_addr, out_data.mem_req_addr);
        if (out_data.mem_req_data !== e.mem_req_data)
          report("mem_req_data", e.mem_req_data, out_data.mem_req_data);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// ===== blocking_writeback_cache_top.f =====
rtl/bwc_pkg.sv
rtl/blocking_writeback_cache_top.sv
rtl/bwc_checker.sv
tb/sv/blocking_writeback_cache_top_test.sv
